@@ rtl/core/acflw_pkg.sv @@
package acflw_pkg;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_FILL  = 2'd2,
        KIND_BAD   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        RES_READ   = 3'd0,
        RES_WDONE  = 3'd1,
        RES_FETCH  = 3'd2,
        RES_WBACK  = 3'd3,
        RES_WTHRU  = 3'd4,
        RES_ERROR  = 3'd5
    } res_kind_t;

    typedef enum logic [0:0] {
        REG_WRITE_BACK_MODE = 1'd0,
        REG_REPLACE_LRU     = 1'd1
    } reg_index_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [31:0] data;
    } req_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [31:0] out_addr;
        logic [31:0] out_data;
        logic [5:0]  slot;
        logic        last;
    } res_t;

endpackage

@@ rtl/core/acflw_queue.sv @@
module acflw_queue #(
    parameter int WIDTH = 66
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wptr_reg, rptr_reg;
    logic [1:0]       count_reg;
    logic             push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop) begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

@@ rtl/core/acflw_back.sv @@
module acflw_back #(
    parameter int ENTRIES   = 8,
    parameter int ADDR_BITS = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_ready,
    input  acflw_pkg::req_t q_req,
    input  logic            write_back_mode,
    input  logic            replace_lru,
    output logic            r_valid,
    input  logic            r_ready,
    output acflw_pkg::res_t r_res
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AW = (ADDR_BITS < 32) ? ADDR_BITS : 32;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_EMIT  = 4'b0100,
        ST_EMIT2 = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [AW-1:0]    tag_reg    [ENTRIES];
    logic [31:0]      value_reg  [ENTRIES];
    logic [ENTRIES-1:0] valid_reg, dirty_reg;
    logic [31:0]      ins_reg    [ENTRIES];
    logic [31:0]      use_reg    [ENTRIES];
    logic [31:0]      stamp_reg;
    logic             pend_reg, pend_wr_reg;
    logic [AW-1:0]    pend_addr_reg;
    logic [31:0]      pend_data_reg;
    logic [1:0]       kind_reg;
    logic [AW-1:0]    addr_reg;
    logic [31:0]      data_reg;
    logic [IW:0]      scan_reg;
    logic [IW-1:0]    best_reg;
    logic [31:0]      best_stamp_reg;
    logic             found_reg;
    logic             free_reg;
    logic [IW-1:0]    hit_idx;
    logic             hit;
    acflw_pkg::res_t  res_reg, res2_reg;
    logic             two_reg;
    logic [31:0]      stamp_inc;
    logic [IW-1:0]    sidx;
    logic [31:0]      cur_stamp;
    logic             scan_err;
    logic             victim_dirty;
    logic [2:0]       done_kind;
    logic [31:0]      done_data;

    assign q_ready   = (state_reg == ST_IDLE);
    assign r_valid   = (state_reg == ST_EMIT) || (state_reg == ST_EMIT2);
    assign r_res     = (state_reg == ST_EMIT2) ? res2_reg : res_reg;
    assign stamp_inc = (stamp_reg == 32'hFFFF_FFFF) ? stamp_reg : stamp_reg + 32'd1;
    assign sidx      = scan_reg[IW-1:0];
    assign cur_stamp = replace_lru ? use_reg[sidx] : ins_reg[sidx];
    assign scan_err  = (kind_reg == acflw_pkg::KIND_BAD)
                       || ((kind_reg == acflw_pkg::KIND_FILL) != pend_reg);
    assign victim_dirty = valid_reg[best_reg] && dirty_reg[best_reg];
    assign done_kind = pend_wr_reg ?
        (write_back_mode ? acflw_pkg::RES_WDONE : acflw_pkg::RES_WTHRU)
        : acflw_pkg::RES_READ;
    assign done_data = pend_wr_reg ? pend_data_reg : data_reg;

    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (valid_reg[i] && tag_reg[i] == addr_reg) begin
                hit     = 1'b1;
                hit_idx = IW'(i);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (q_valid) state_next = ST_SCAN;
            ST_SCAN: begin
                if (scan_err || kind_reg != acflw_pkg::KIND_FILL
                    || scan_reg == (IW+1)'(ENTRIES)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:  if (r_ready) state_next = two_reg ? ST_EMIT2 : ST_IDLE;
            ST_EMIT2: if (r_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            dirty_reg <= '0;
            stamp_reg <= '0;
            pend_reg  <= 1'b0;
            pend_wr_reg <= 1'b0;
            pend_addr_reg <= '0;
            pend_data_reg <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                tag_reg[i] <= '0;
                ins_reg[i] <= '0;
                use_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    kind_reg       <= q_req.kind;
                    addr_reg       <= q_req.addr[AW-1:0];
                    data_reg       <= q_req.data;
                    scan_reg       <= '0;
                    found_reg      <= 1'b0;
                    free_reg       <= 1'b0;
                    best_reg       <= '0;
                    best_stamp_reg <= '0;
                end
                ST_SCAN: begin
                    if (scan_err) begin
                        two_reg             <= 1'b0;
                        res_reg.result_kind <= acflw_pkg::RES_ERROR;
                        res_reg.out_addr    <= 32'(addr_reg);
                        res_reg.out_data    <= '0;
                        res_reg.slot        <= '0;
                        res_reg.last        <= 1'b1;
                    end else if (kind_reg != acflw_pkg::KIND_FILL) begin
                        two_reg          <= 1'b0;
                        res_reg.out_addr <= 32'(addr_reg);
                        res_reg.last     <= 1'b1;
                        if (!hit) begin
                            pend_reg      <= 1'b1;
                            pend_wr_reg   <= (kind_reg == acflw_pkg::KIND_WRITE);
                            pend_addr_reg <= addr_reg;
                            pend_data_reg <= (kind_reg == acflw_pkg::KIND_WRITE) ? data_reg : '0;
                            res_reg.result_kind <= acflw_pkg::RES_FETCH;
                            res_reg.out_data    <= '0;
                            res_reg.slot        <= '0;
                        end else begin
                            stamp_reg        <= stamp_inc;
                            use_reg[hit_idx] <= stamp_inc;
                            res_reg.slot     <= 6'(hit_idx);
                            if (kind_reg == acflw_pkg::KIND_READ) begin
                                res_reg.result_kind <= acflw_pkg::RES_READ;
                                res_reg.out_data    <= value_reg[hit_idx];
                            end else begin
                                value_reg[hit_idx] <= data_reg;
                                dirty_reg[hit_idx] <= write_back_mode;
                                res_reg.out_data   <= data_reg;
                                res_reg.result_kind <= write_back_mode ?
                                    acflw_pkg::RES_WDONE : acflw_pkg::RES_WTHRU;
                            end
                        end
                    end else if (scan_reg != (IW+1)'(ENTRIES)) begin
                        scan_reg <= scan_reg + 1'b1;
                        if (!free_reg) begin
                            if (!valid_reg[sidx]) begin
                                free_reg <= 1'b1;
                                best_reg <= sidx;
                            end else if (!found_reg || cur_stamp < best_stamp_reg) begin
                                found_reg      <= 1'b1;
                                best_reg       <= sidx;
                                best_stamp_reg <= cur_stamp;
                            end
                        end
                    end else begin
                        stamp_reg           <= stamp_inc;
                        tag_reg[best_reg]   <= pend_addr_reg;
                        value_reg[best_reg] <= done_data;
                        valid_reg[best_reg] <= 1'b1;
                        dirty_reg[best_reg] <= pend_wr_reg && write_back_mode;
                        ins_reg[best_reg]   <= stamp_inc;
                        use_reg[best_reg]   <= stamp_inc;
                        pend_reg            <= 1'b0;
                        pend_wr_reg         <= 1'b0;
                        res2_reg.result_kind <= done_kind;
                        res2_reg.out_addr <= 32'(pend_addr_reg);
                        res2_reg.out_data <= done_data;
                        res2_reg.slot     <= 6'(best_reg);
                        res2_reg.last     <= 1'b1;
                        res_reg.slot      <= 6'(best_reg);
                        two_reg           <= victim_dirty;
                        if (victim_dirty) begin
                            res_reg.result_kind <= acflw_pkg::RES_WBACK;
                            res_reg.out_addr    <= 32'(tag_reg[best_reg]);
                            res_reg.out_data    <= value_reg[best_reg];
                            res_reg.last        <= 1'b0;
                        end else begin
                            res_reg.result_kind <= done_kind;
                            res_reg.out_addr    <= 32'(pend_addr_reg);
                            res_reg.out_data    <= done_data;
                            res_reg.last        <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/core/assoc_cache_fifo_lru_wb_wt.sv @@
// Channel   Ports                                 Direction
// request   s_valid s_ready s_kind s_addr s_data  in
// result    m_valid m_ready m_result_kind m_out_addr m_out_data m_slot m_last  out
// A read or write is taken from the queue head in idle, looked up in scan and
// answered in emit; a fill scans the ENTRIES entries one per cycle for a victim.
// The two-entry request queue keeps taking requests while the back end works, until it is full.
// Reset invalidates all entries and clears stamps, the pending miss and both registers.
// A stalled result holds the back end; requests then wait in the queue.
module assoc_cache_fifo_lru_wb_wt #(
    parameter int ENTRIES   = 8,
    parameter int ADDR_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [31:0] s_addr,
    input  logic [31:0] s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_result_kind,
    output logic [31:0] m_out_addr,
    output logic [31:0] m_out_data,
    output logic [5:0]  m_slot,
    output logic        m_last,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_wdata
);

    logic            wb_reg, lru_reg;
    acflw_pkg::req_t in_req, q_req;
    acflw_pkg::res_t res;
    logic            q_valid, q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_reg  <= 1'b0;
            lru_reg <= 1'b0;
        end else if (cfg_we) begin
            if (cfg_index == acflw_pkg::REG_WRITE_BACK_MODE) wb_reg <= cfg_wdata;
            else lru_reg <= cfg_wdata;
        end
    end

    assign in_req.kind = s_kind;
    assign in_req.addr = s_addr;
    assign in_req.data = s_data;

    acflw_queue #(.WIDTH($bits(acflw_pkg::req_t))) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_data(in_req),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_req)
    );

    acflw_back #(.ENTRIES(ENTRIES), .ADDR_BITS(ADDR_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .write_back_mode(wb_reg), .replace_lru(lru_reg),
        .r_valid(m_valid), .r_ready(m_ready), .r_res(res)
    );

    assign m_result_kind = res.result_kind;
    assign m_out_addr    = res.out_addr;
    assign m_out_data    = res.out_data;
    assign m_slot        = res.slot;
    assign m_last        = res.last;

endmodule
